[rtl/asp_pkg.sv]
package asp_pkg;

  localparam logic [31:0] LOG_BIAS = 32'd1064631197;
  localparam logic [47:0] EXP_BIAS = 48'd1065353217;
  localparam logic [30:0] PB_MAX   = 31'h7F7FFFFF;
  localparam logic [31:0] PI_Q30   = 32'd3373259426;
  localparam logic [30:0] G1_Q30   = 31'd1377809732;
  localparam logic [27:0] G2_Q30   = 28'd152033954;

  localparam int MUL_W  = 36;
  localparam int PROD_W = 72;
  localparam int DIV_QW = 31;

  localparam logic [1:0] CFG_NUM_PARTIALS = 2'd0;
  localparam logic [1:0] CFG_FIRST_OFFSET = 2'd1;
  localparam logic [1:0] CFG_PERIOD       = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_SPOW, ST_SMUL, ST_DPOW, ST_P0, ST_P1, ST_SUMP, ST_PH,
    ST_X2, ST_T1, ST_T2, ST_Y, ST_MAG, ST_W, ST_AMP, ST_ACC, ST_DONE
  } state_t;

  typedef struct packed {
    logic        start;
    logic [23:0] divisor;
    logic [5:0]  shift;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // IEEE single bit pattern of a small positive integer.
  function automatic logic [31:0] int_bits(input logic [6:0] n);
    logic [2:0]  p;
    logic [6:0]  frac;
    logic [7:0]  ex;
    logic [22:0] mant;
    p = 3'd0;
    for (int i = 1; i < 7; i++) begin
      if (n[i]) p = 3'(i);
    end
    frac = n - (7'd1 << p);
    ex   = 8'd127 + {5'd0, p};
    mant = 23'(frac) << (5'd23 - {2'd0, p});
    return {1'b0, ex, mant};
  endfunction

  // Finishes the linear exponent trick from the product |x|*|q|.
  function automatic logic [30:0] pow_finish(input logic [41:0] prod, input logic neg,
                                             input logic f14);
    logic [47:0] bias;
    logic [47:0] sum;
    logic [47:0] r;
    bias = f14 ? (EXP_BIAS << 14) : (EXP_BIAS << 12);
    if (neg) begin
      sum = ({6'd0, prod} > bias) ? 48'd0 : bias - {6'd0, prod};
    end else begin
      sum = bias + {6'd0, prod};
    end
    r = f14 ? (sum >> 14) : (sum >> 12);
    return (r > {17'd0, PB_MAX}) ? PB_MAX : r[30:0];
  endfunction

endpackage

[rtl/additive_sine_partial_bank_top.sv]
// Channel | Dir | Signals                      | Content
// in      | in  | in_tvalid/tready/tdata[71:0] | base_freq, decay_exponent, odd_even, stretch
// out     | out | out_tvalid/tready/tdata[23:0]| sample
// cfg     | in  | cfg_we/index[1:0]/wdata[35:0]| num_partials, first_partial_offset, period
// Each partial steps through ST_LOAD to ST_ACC and waits in ST_W for the 31-step decay divider;
// no new request is taken until the sample is finished.
// All multiplications pass through one 36 by 36 bit multiplier with a registered product.
// Reset is synchronous and active low; phases read as zero until first written.
// A finished sample waits in the output register while the next request is accepted.
module additive_sine_partial_bank_top
  import asp_pkg::*;
#(
  parameter int MAX_PARTIALS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,  // base_freq, decay_exponent, odd_even, stretch, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // sample, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [35:0] cfg_wdata
);

  localparam int AW    = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;
  localparam int CW    = $clog2(MAX_PARTIALS + 1);
  localparam int SUM_W = 34 + $clog2(MAX_PARTIALS);

  state_t state_r, state_nxt;

  logic [4:0]  num_r, off_r;
  logic [35:0] per_r;
  logic [20:0] base_r;
  logic [15:0] decay_r;
  logic signed [15:0] oe_r, st_r;
  logic [CW-1:0] cnt_r, k_r;
  logic [27:0] am_r;
  logic [51:0] am50_r;
  logic signed [8:0] ex_r;
  logic [61:0] plo_r;
  logic [87:0] pp_r;
  logic [31:0] phase_r, newph_r;
  logic        aud_r, neg_r, dzero_r, rvalid_r;
  logic [30:0] ax_r, x2_r, mag_r;
  logic signed [SUM_W-1:0] sum_r;
  logic        out_valid_r;
  logic [19:0] out_sample_r;
  logic [MAX_PARTIALS-1:0] pvalid_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  div_req_t          dreq;
  div_stat_t         dstat;
  logic [DIV_QW-1:0] dquo;
  logic [31:0]       ram_rdata;
  logic              ram_we;

  logic [CW-1:0] cnt_in;
  logic [6:0]    nh;
  logic [15:0]   st_abs;
  logic [31:0]   xs_full, xd_full;
  logic [30:0]   pbs, pbd;
  logic          use_st;
  logic [15:0]   w;
  logic signed [16:0] w_full;
  logic signed [9:0]  s, n2;
  logic [9:0]    nsh;
  logic [89:0]   p3;
  logic [87:0]   shl, shr;
  logic [89:0]   p3sh;
  logic [31:0]   incr;
  logic          aud;
  logic signed [31:0] xq;
  logic [31:0]   term;
  logic [SUM_W-1:0] sabs, squo;
  logic [19:0]   sat;

  asp_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_r(mul_p));

  asp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .stat(dstat), .quo_r(dquo));

  asp_ram #(.WIDTH(32), .DEPTH(MAX_PARTIALS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(k_r[AW-1:0]), .wdata(newph_r),
    .raddr(k_r[AW-1:0]), .rdata_r(ram_rdata)
  );

  always_comb begin
    cnt_in  = ({{(CW > 5 ? CW - 5 : 0){1'b0}}, num_r} > CW'(MAX_PARTIALS)) ?
              CW'(MAX_PARTIALS) : CW'(num_r);
    nh      = 7'(k_r) + 7'd1 + 7'(off_r);
    st_abs  = st_r[15] ? 16'(-st_r) : st_r;
    xs_full = int_bits(7'(k_r)) - LOG_BIAS;
    xd_full = int_bits(7'(k_r) + 7'd1) - LOG_BIAS;
    use_st  = (k_r != '0) && (st_r != 16'sd0);
    pbs     = pow_finish(mul_p[41:0], st_r[15], 1'b1);
    pbd     = pow_finish(mul_p[41:0], 1'b0, 1'b0);
    if (!k_r[0]) w_full = (oe_r > 16'sd0) ? 17'sd32768 - 17'(oe_r) : 17'sd32768;
    else         w_full = (oe_r < 16'sd0) ? 17'sd32768 + 17'(oe_r) : 17'sd32768;
    w = w_full[15:0];

    s    = {ex_r[8], ex_r} - 10'sd20;
    n2   = 10'sd52 - {ex_r[8], ex_r};
    nsh  = 10'(-s);
    p3   = {2'b0, pp_r} + {1'b0, pp_r, 1'b0};
    shl  = pp_r << s[4:0];
    shr  = pp_r >> nsh[6:0];
    p3sh = p3 >> n2[6:0];
    if (!s[9]) begin
      if (pp_r == '0) incr = 32'd0;
      else if (s >= 10'sd31) incr = 32'h8000_0000;
      else if ((pp_r >> (6'd31 - s[5:0])) != '0) incr = 32'h8000_0000;
      else incr = shl[31:0];
    end else begin
      if (nsh >= 10'd88) incr = 32'd0;
      else if (shr >= 88'h8000_0000) incr = 32'h8000_0000;
      else incr = shr[31:0];
    end
    if (n2 <= 10'sd0) aud = (pp_r == '0);
    else if (n2 >= 10'sd90) aud = 1'b1;
    else aud = (p3sh == '0);

    xq   = {1'b0, newph_r[30:0]} - 32'sh4000_0000;
    term = mul_p[61:30];
    sabs = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : sum_r;
    squo = sabs >> 15;
    if (!sum_r[SUM_W-1]) sat = (squo > SUM_W'(524287)) ? 20'h7FFFF : squo[19:0];
    else sat = (squo > SUM_W'(524288)) ? 20'h80000 : 20'(-squo[19:0]);
  end

  always_comb begin
    state_nxt    = state_r;
    mul_a        = '0;
    mul_b        = '0;
    dreq.start   = 1'b0;
    dreq.divisor = {1'b1, pbd[22:0]};
    dreq.shift   = 6'(8'd180 - pbd[30:23]);
    ram_we       = 1'b0;
    in_tready    = (state_r == ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = (cnt_in == '0) ? ST_DONE : ST_LOAD;
      end
      ST_LOAD: begin
        mul_a = MUL_W'(base_r);
        mul_b = MUL_W'(nh);
        state_nxt = ST_SPOW;
      end
      ST_SPOW: begin
        mul_a = MUL_W'(xs_full[25:0]);
        mul_b = MUL_W'(st_abs);
        state_nxt = ST_SMUL;
      end
      ST_SMUL: begin
        mul_a = MUL_W'(am_r);
        mul_b = use_st ? MUL_W'({1'b1, pbs[22:0]}) : MUL_W'(1);
        state_nxt = ST_DPOW;
      end
      ST_DPOW: begin
        mul_a = MUL_W'(xd_full[25:0]);
        mul_b = MUL_W'(decay_r);
        state_nxt = ST_P0;
      end
      ST_P0: begin
        dreq.start = 1'b1;
        mul_a = MUL_W'(am50_r[25:0]);
        mul_b = per_r;
        state_nxt = ST_P1;
      end
      ST_P1: begin
        mul_a = MUL_W'(am50_r[51:26]);
        mul_b = per_r;
        state_nxt = ST_SUMP;
      end
      ST_SUMP: state_nxt = ST_PH;
      ST_PH: begin
        state_nxt = ST_X2;
      end
      ST_X2: begin
        ram_we = 1'b1;
        mul_a = MUL_W'(xq[31] ? 31'(-xq) : xq[30:0]);
        mul_b = mul_a;
        state_nxt = ST_T1;
      end
      ST_T1: begin
        mul_a = MUL_W'(mul_p[60:30]);
        mul_b = MUL_W'(G2_Q30);
        state_nxt = ST_T2;
      end
      ST_T2: begin
        mul_a = MUL_W'(x2_r);
        mul_b = MUL_W'(G1_Q30 - mul_p[60:30]);
        state_nxt = ST_Y;
      end
      ST_Y: begin
        mul_a = MUL_W'(ax_r);
        mul_b = MUL_W'(PI_Q30 - {1'b0, mul_p[60:30]});
        state_nxt = ST_MAG;
      end
      ST_MAG: state_nxt = ST_W;
      ST_W: begin
        mul_a = dzero_r ? '0 : MUL_W'(dquo);
        mul_b = MUL_W'(w);
        if (dstat.done) state_nxt = ST_AMP;
      end
      ST_AMP: begin
        mul_a = MUL_W'(mag_r);
        mul_b = MUL_W'(mul_p[45:15]);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = (k_r + CW'(1) < cnt_r) ? ST_LOAD : ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pvalid_r    <= '0;
      num_r       <= 5'd6;
      off_r       <= 5'd0;
      per_r       <= 36'd5864062015;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_PARTIALS: num_r <= cfg_wdata[4:0];
          CFG_FIRST_OFFSET: off_r <= cfg_wdata[4:0];
          CFG_PERIOD:       per_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (ram_we) pvalid_r[k_r[AW-1:0]] <= 1'b1;
      if (state_r == ST_DONE && state_nxt == ST_IDLE) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        base_r  <= in_tdata[20:0];
        decay_r <= in_tdata[36:21];
        oe_r    <= in_tdata[52:37];
        st_r    <= in_tdata[68:53];
        cnt_r   <= cnt_in;
        k_r     <= '0;
        sum_r   <= '0;
      end
      ST_LOAD: rvalid_r <= pvalid_r[k_r[AW-1:0]];
      ST_SPOW: begin
        am_r    <= mul_p[27:0];
        phase_r <= rvalid_r ? ram_rdata : 32'd0;
      end
      ST_SMUL: ex_r <= use_st ? 9'($signed({1'b0, pbs[30:23]}) - 9'sd150) : 9'sd0;
      ST_DPOW: am50_r <= mul_p[51:0];
      ST_P0:   dzero_r <= (pbd[30:23] > 8'd180);
      ST_P1:   plo_r <= mul_p[61:0];
      ST_SUMP: pp_r <= {26'd0, plo_r} + ({26'd0, mul_p[61:0]} << 26);
      ST_PH: begin
        newph_r <= phase_r + incr;
        aud_r   <= aud;
      end
      ST_X2: begin
        ax_r  <= xq[31] ? 31'(-xq) : xq[30:0];
        neg_r <= xq[31] ^ newph_r[31];
      end
      ST_T1:  x2_r <= mul_p[60:30];
      ST_MAG: mag_r <= mul_p[61:31];
      ST_ACC: begin
        if (aud_r) sum_r <= neg_r ? sum_r - SUM_W'(term) : sum_r + SUM_W'(term);
        k_r <= k_r + CW'(1);
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) out_sample_r <= sat;
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, out_sample_r};

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("request taken while busy");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC) |-> (k_r < cnt_r)) else $error("partial index overrun");

  a_amp_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_AMP) |-> $past(dstat.done)) else $error("decay used before divide");

  a_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !ram_we) else $error("phase written twice in a row");

endmodule

[rtl/asp_mul.sv]
module asp_mul
  import asp_pkg::*;
(
  input  logic              clk,
  input  logic [MUL_W-1:0]  a,
  input  logic [MUL_W-1:0]  b,
  output logic [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

[rtl/asp_div.sv]
module asp_div
  import asp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output div_stat_t         stat,
  output logic [DIV_QW-1:0] quo_r
);

  logic [23:0] rem_r;
  logic [23:0] m_r;
  logic [5:0]  sh_r;
  logic [4:0]  i_r;
  logic        busy_r;
  logic        done_r;
  logic [24:0] r2;
  logic        qbit;

  always_comb begin
    r2   = {rem_r, ({1'b0, i_r} == sh_r)};
    qbit = (r2 >= {1'b0, m_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && i_r == 5'd0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      m_r   <= req.divisor;
      sh_r  <= req.shift;
      i_r   <= 5'd30;
      quo_r <= '0;
      rem_r <= (req.shift >= 6'd31) ? (24'd1 << (req.shift - 6'd31)) : 24'd0;
    end else if (busy_r) begin
      rem_r <= qbit ? 24'(r2 - {1'b0, m_r}) : r2[23:0];
      quo_r <= {quo_r[DIV_QW-2:0], qbit};
      i_r   <= i_r - 5'd1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

[rtl/asp_ram.sv]
module asp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

endmodule
